>>> rtl/masked_key_record_sorter_assert.svh
// Assertion macros used by the checker file of the record sorter.
`ifndef MASKED_KEY_RECORD_SORTER_ASSERT_SVH
`define MASKED_KEY_RECORD_SORTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MKRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MKRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/mkrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mkrs_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned KEY_W  = 48;

  // One record as held in a sorter cell
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] primary;
    logic [WORD_W-1:0] secondary;
  } rec_t;

  // Chain-wide control for the current cycle
  typedef struct packed {
    logic insert;
    logic shift;
  } ctrl_t;

  // True when record a must come strictly after record b
  function automatic logic key_gt(input rec_t a, input rec_t b);
    logic [2*KEY_W-1:0] ka;
    logic [2*KEY_W-1:0] kb;
    ka = {a.primary[KEY_W-1:0], a.secondary[KEY_W-1:0]};
    kb = {b.primary[KEY_W-1:0], b.secondary[KEY_W-1:0]};
    return ka > kb;
  endfunction

endpackage
`default_nettype wire

>>> rtl/mkrs_rec_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mkrs_rec_if;
  logic        valid;
  logic        ready;
  logic [63:0] primary_word;
  logic [63:0] secondary_word;
  logic        last_record;

  modport source (output valid, output primary_word, output secondary_word,
                  output last_record, input ready);
  modport sink   (input valid, input primary_word, input secondary_word,
                  input last_record, output ready);
endinterface
`default_nettype wire

>>> rtl/mkrs_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mkrs_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] sorted_primary;
  logic [63:0] sorted_secondary;
  logic        last_output;
  logic        overflow;

  modport source (output valid, output sorted_primary, output sorted_secondary,
                  output last_output, output overflow, input ready);
  modport sink   (input valid, input sorted_primary, input sorted_secondary,
                  input last_output, input overflow, output ready);
endinterface
`default_nettype wire

>>> rtl/mkrs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mkrs_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mkrs_pkg::ctrl_t ctrl_i,
  input  wire mkrs_pkg::rec_t  new_rec_i,
  input  wire mkrs_pkg::rec_t  left_rec_i,
  input  wire logic          left_gt_i,
  input  wire mkrs_pkg::rec_t  right_rec_i,
  output mkrs_pkg::rec_t     rec_o,
  output logic               gt_o
);

  mkrs_pkg::rec_t rec_q;
  mkrs_pkg::rec_t rec_d;

  // Empty cells count as larger than any record
  assign gt_o = !rec_q.valid || mkrs_pkg::key_gt(rec_q, new_rec_i);

  // Drain toward the output, or make room for the new record
  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.shift) begin
      rec_d = right_rec_i;
    end else if (ctrl_i.insert && gt_o) begin
      rec_d = left_gt_i ? left_rec_i : new_rec_i;
    end
  end

  // Hold the record; reset empties the cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule
`default_nettype wire

>>> rtl/masked_key_record_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: one record per cycle between unloads; each with room enters the chain in the cycle it transfers.
// After the record marked last, the first result is shown on the next cycle.
// Unload: one result per cycle while the sink is ready, MAX_RECORDS results at most per batch.
// No record is taken while a batch unloads; set by the single chain of cells.
// Reset (rst_ni low, asynchronous) empties every cell and clears the count and drop flag.
module masked_key_record_sorter #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mkrs_rec_if.sink    rec_i,
  mkrs_res_if.source  res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

  mkrs_pkg::rec_t  cell_rec [MAX_RECORDS];
  logic            cell_gt  [MAX_RECORDS];
  mkrs_pkg::rec_t  new_rec;
  mkrs_pkg::ctrl_t ctrl;

  logic [CNT_W-1:0] count_q, count_d;
  logic             dropped_q, dropped_d;
  logic             drain_q, drain_d;
  logic             in_xfer, out_xfer, room;

  assign rec_i.ready = !drain_q;
  assign in_xfer     = rec_i.valid && rec_i.ready;
  assign out_xfer    = res_o.valid && res_o.ready;
  assign room        = count_q < CNT_W'(MAX_RECORDS);

  assign new_rec.valid     = 1'b1;
  assign new_rec.primary   = rec_i.primary_word;
  assign new_rec.secondary = rec_i.secondary_word;

  assign ctrl.insert = in_xfer && room;
  assign ctrl.shift  = out_xfer;

  // Chain of sorting cells, lowest key at cell 0
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    mkrs_pkg::rec_t left_rec, right_rec;
    logic           left_gt;
    if (i == 0) begin : g_head
      assign left_rec = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_rec = cell_rec[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_tail
      assign right_rec = '0;
    end else begin : g_body
      assign right_rec = cell_rec[i+1];
    end
    mkrs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_rec_i   (new_rec),
      .left_rec_i  (left_rec),
      .left_gt_i   (left_gt),
      .right_rec_i (right_rec),
      .rec_o       (cell_rec[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // Track batch fill, drops and the unload phase
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    drain_d   = drain_q;
    if (in_xfer) begin
      if (room) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        dropped_d = 1'b1;
      end
      if (rec_i.last_record) begin
        drain_d = 1'b1;
      end
    end
    if (out_xfer && res_o.last_output) begin
      count_d   = '0;
      dropped_d = 1'b0;
      drain_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      drain_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      drain_q   <= drain_d;
    end
  end

  // Present the head cell as the result
  assign res_o.valid            = drain_q && cell_rec[0].valid;
  assign res_o.sorted_primary   = cell_rec[0].primary;
  assign res_o.sorted_secondary = cell_rec[0].secondary;
  assign res_o.last_output      = !cell_rec[1].valid;
  assign res_o.overflow         = dropped_q;

endmodule
`default_nettype wire

>>> rtl/mkrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "masked_key_record_sorter_assert.svh"
module mkrs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_last_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        out_last_i,
  input wire logic [63:0] out_primary_i
);

  // No record is taken while results are offered
  `MKRS_ASSERT_NOW(a_no_load_in_unload, out_valid_i, !in_ready_i)
  // The record marked last starts the unload on the next cycle
  `MKRS_ASSERT_NEXT(a_unload_follows_last, in_valid_i && in_ready_i && in_last_i, out_valid_i)
  // The final result transfer reopens the input
  `MKRS_ASSERT_NEXT(a_reopen_after_last, out_valid_i && out_ready_i && out_last_i, in_ready_i)
  // A stalled result holds
  `MKRS_ASSERT_NEXT(a_stall_holds, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(out_primary_i))

endmodule

bind masked_key_record_sorter mkrs_checker u_mkrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (rec_i.valid),
  .in_ready_i    (rec_i.ready),
  .in_last_i     (rec_i.last_record),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_last_i    (res_o.last_output),
  .out_primary_i (res_o.sorted_primary)
);
`default_nettype wire
